@@ src/swsd_pkg.sv @@
// ----------------------------------------------------------------------------
// swsd_pkg
// Shared types and constants for the steering wheel speed differential.
// ----------------------------------------------------------------------------
package swsd_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_TOE_MODE   = 3'd0;
  localparam logic [2:0] CFG_TOE_ANGLE  = 3'd1;
  localparam logic [2:0] CFG_TURN_DIR   = 3'd2;
  localparam logic [2:0] CFG_HALF_TRACK = 3'd3;
  localparam logic [2:0] CFG_MAX_ANGLE  = 3'd4;
  localparam logic [2:0] CFG_CENTRE     = 3'd5;
  localparam logic [2:0] CFG_AMPLITUDE  = 3'd6;

  localparam int CFG_DATA_W = 16;

  // Geometry constants
  localparam logic [10:0] RADIUS_SCALE = 11'd1350;
  localparam logic [7:0]  ANGLE_LIMIT  = 8'd180;

  // Divider chain sizes: angle quotient, radius quotient, ratio quotient
  localparam int ANG_NW = 23;
  localparam int RAD_NW = 11;
  localparam int RAT_NW = 28;

  // CORDIC datapath
  localparam int CORDIC_STEPS = 16;
  localparam int XY_W = 26;
  localparam int Z_W  = 18;

  // round(atan(2^-i) * 4/pi * 16384)
  localparam logic [14:0] CORDIC_TAB [CORDIC_STEPS] = '{
    15'd16384, 15'd9672, 15'd5110, 15'd2594, 15'd1302, 15'd652, 15'd326, 15'd163,
    15'd81, 15'd41, 15'd20, 15'd10, 15'd5, 15'd3, 15'd1, 15'd1
  };

  // Per-item sideband that travels down the cell chain
  typedef struct packed {
    logic               side;
    logic signed [15:0] speed;
    logic               flag;   // sign of the current quotient or add/sub choice
    logic               zero;   // zero steering angle: speed passes through
  } sb_t;

endpackage

@@ src/swsd_in_if.sv @@
// ----------------------------------------------------------------------------
// swsd_in_if
// Input channel: wheel side, base speed and servo position.
// ----------------------------------------------------------------------------
interface swsd_in_if;
  logic               valid;
  logic               ready;
  logic               wheel_side;
  logic signed [15:0] base_speed;
  logic [15:0]        servo_position;

  modport source (output valid, wheel_side, base_speed, servo_position, input ready);
  modport sink   (input valid, wheel_side, base_speed, servo_position, output ready);
endinterface

@@ src/swsd_out_if.sv @@
// ----------------------------------------------------------------------------
// swsd_out_if
// Output channel: adjusted wheel speed.
// ----------------------------------------------------------------------------
interface swsd_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] wheel_speed;

  modport source (output valid, wheel_speed, input ready);
  modport sink   (input valid, wheel_speed, output ready);
endinterface

@@ src/swsd_div_cell.sv @@
// ----------------------------------------------------------------------------
// swsd_div_cell
// One restoring-division step: shifts in one dividend bit, emits one
// quotient bit, and hands the partial result to the next cell.
// ----------------------------------------------------------------------------
module swsd_div_cell #(
  parameter int NW = 8,   // dividend / quotient width
  parameter int DW = 8    // divisor / remainder width
) (
  input  logic           clk,
  input  logic           en,
  input  logic [DW-1:0]  prev_rem,
  input  logic [NW-1:0]  prev_num,
  input  logic [DW-1:0]  prev_den,
  input  swsd_pkg::sb_t  prev_sb,
  output logic [DW-1:0]  rem,
  output logic [NW-1:0]  num,
  output logic [DW-1:0]  den,
  output swsd_pkg::sb_t  sb
);
  import swsd_pkg::*;

  logic [DW:0]   part;
  logic [DW:0]   diff;
  logic          take;
  logic [DW-1:0] rem_next;
  logic [NW-1:0] num_next;

  // trial subtract
  always_comb begin
    part     = {prev_rem, prev_num[NW-1]};
    diff     = part - {1'b0, prev_den};
    take     = (part >= {1'b0, prev_den});
    rem_next = take ? diff[DW-1:0] : part[DW-1:0];
    num_next = {prev_num[NW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= rem_next;
      num <= num_next;
      den <= prev_den;
      sb  <= prev_sb;
    end
  end

endmodule

@@ src/swsd_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// swsd_cordic_cell
// One CORDIC vectoring step: rotates (x, y) toward y = 0 and accumulates
// the scaled arctangent in z.
// ----------------------------------------------------------------------------
module swsd_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [swsd_pkg::XY_W-1:0]   prev_x,
  input  logic signed [swsd_pkg::XY_W-1:0]   prev_y,
  input  logic signed [swsd_pkg::Z_W-1:0]    prev_z,
  input  swsd_pkg::sb_t                      prev_sb,
  output logic signed [swsd_pkg::XY_W-1:0]   x,
  output logic signed [swsd_pkg::XY_W-1:0]   y,
  output logic signed [swsd_pkg::Z_W-1:0]    z,
  output swsd_pkg::sb_t                      sb
);
  import swsd_pkg::*;

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  da;
  logic signed [XY_W-1:0] x_next;
  logic signed [XY_W-1:0] y_next;
  logic signed [Z_W-1:0]  z_next;

  // arithmetic shifts floor toward minus infinity
  always_comb begin
    xs = prev_x >>> STEP;
    ys = prev_y >>> STEP;
    da = $signed({{(Z_W-15){1'b0}}, CORDIC_TAB[STEP]});
    if (!prev_y[XY_W-1]) begin
      x_next = prev_x + ys;
      y_next = prev_y - xs;
      z_next = prev_z + da;
    end else begin
      x_next = prev_x - ys;
      y_next = prev_y + xs;
      z_next = prev_z - da;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x  <= x_next;
      y  <= y_next;
      z  <= z_next;
      sb <= prev_sb;
    end
  end

endmodule

@@ src/steering_wheel_speed_differential_top.sv @@
// ----------------------------------------------------------------------------
// steering_wheel_speed_differential_top
// Electronic differential: per-wheel target speed from servo position.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while the output buffer is not
// full and returns one result per transaction, in order, through 84
// pipeline stages plus the output register: 23 divider cells for the
// steering angle, 11 for the turn radius, 28 for the Q8.16 wheel ratio,
// 16 CORDIC cells for the arctangent factor, and glue stages in between.
// A two-entry output buffer lets the pipeline keep taking transactions
// while one result waits. Configuration must be written through
// cfg_we/cfg_index/cfg_data while the block is idle; it is not enforced.
module steering_wheel_speed_differential_top (
  input  logic                              clk,
  input  logic                              rst,
  swsd_in_if.sink                           item,
  swsd_out_if.source                        result,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_index,
  input  logic [swsd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import swsd_pkg::*;

  // Stage positions
  localparam int ST_A  = 1;
  localparam int ST_S1 = ST_A + ANG_NW;
  localparam int ST_R  = ST_S1 + 1;
  localparam int ST_S2 = ST_R + RAD_NW;
  localparam int ST_B  = ST_S2 + 1;
  localparam int ST_S3 = ST_B + RAT_NW;
  localparam int ST_C  = ST_S3 + 1;
  localparam int ST_S4 = ST_C + CORDIC_STEPS;
  localparam int ST_S5 = ST_S4 + 1;
  localparam int NSTG  = ST_S5 + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  logic              toe_in_mode;
  logic [5:0]        toe_in_angle;
  logic signed [1:0] turn_direction_sign;
  logic [9:0]        half_track_width;
  logic [6:0]        max_steer_angle;
  logic [15:0]       servo_centre;
  logic [15:0]       servo_amplitude;

  always_ff @(posedge clk) begin
    if (rst) begin
      toe_in_mode         <= 1'b0;
      toe_in_angle        <= '0;
      turn_direction_sign <= 2'sd1;
      half_track_width    <= '0;
      max_steer_angle     <= 7'd45;
      servo_centre        <= 16'd32768;
      servo_amplitude     <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOE_MODE:   toe_in_mode         <= cfg_data[0];
        CFG_TOE_ANGLE:  toe_in_angle        <= cfg_data[5:0];
        CFG_TURN_DIR:   turn_direction_sign <= $signed(cfg_data[1:0]);
        CFG_HALF_TRACK: half_track_width    <= cfg_data[9:0];
        CFG_MAX_ANGLE:  max_steer_angle     <= cfg_data[6:0];
        CFG_CENTRE:     servo_centre        <= cfg_data[15:0];
        CFG_AMPLITUDE:  servo_amplitude     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage advances together unless the output
  // buffer is full and not draining.
  logic            adv;
  logic [NSTG-1:0] vld;
  logic            out_valid;
  logic            skid_valid;
  logic            pop;
  logic            push;

  assign pop  = out_valid && result.ready;
  assign adv  = !skid_valid || pop;
  assign push = adv && vld[NSTG-1];
  assign item.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], item.valid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: servo offset times max angle, magnitude and sign
  logic signed [16:0] s0_diff;
  logic [15:0]        s0_mag;
  logic [15:0]        amp_eff;
  sb_t                s0_sb;

  always_comb begin
    s0_diff = $signed({1'b0, item.servo_position}) - $signed({1'b0, servo_centre});
    s0_mag  = s0_diff[16] ? 16'(-s0_diff) : s0_diff[15:0];
    amp_eff = (servo_amplitude == 16'd0) ? 16'd1 : servo_amplitude;
    s0_sb.side  = item.wheel_side;
    s0_sb.speed = item.base_speed;
    s0_sb.flag  = s0_diff[16];
    s0_sb.zero  = 1'b0;
  end

  logic [15:0]       a_rem [ANG_NW+1];
  logic [ANG_NW-1:0] a_num [ANG_NW+1];
  logic [15:0]       a_den [ANG_NW+1];
  sb_t               a_sb  [ANG_NW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      a_rem[0] <= '0;
      a_num[0] <= ANG_NW'(s0_mag * max_steer_angle);
      a_den[0] <= amp_eff;
      a_sb[0]  <= s0_sb;
    end
  end

  // Angle divider chain
  for (genvar k = 0; k < ANG_NW; k++) begin : g_ang
    swsd_div_cell #(.NW(ANG_NW), .DW(16)) u_cell (
      .clk(clk), .en(adv),
      .prev_rem(a_rem[k]), .prev_num(a_num[k]), .prev_den(a_den[k]), .prev_sb(a_sb[k]),
      .rem(a_rem[k+1]), .num(a_num[k+1]), .den(a_den[k+1]), .sb(a_sb[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage S1: saturate angle, apply toe-in, pick add or subtract
  logic [ANG_NW-1:0]  s1_q;
  logic [7:0]         s1_m;
  logic signed [9:0]  s1_ang;
  logic signed [9:0]  s1_toe;
  logic signed [9:0]  s1_ang2;
  logic [7:0]         s1_abs;
  logic               s1_negp;
  sb_t                s1_sb;

  always_comb begin
    s1_q   = a_num[ANG_NW];
    s1_m   = (s1_q > ANG_NW'(ANGLE_LIMIT)) ? ANGLE_LIMIT : s1_q[7:0];
    s1_ang = a_sb[ANG_NW].flag ? -$signed({2'b00, s1_m}) : $signed({2'b00, s1_m});
    if (!toe_in_mode) begin
      s1_toe = '0;
    end else if (a_sb[ANG_NW].side) begin
      s1_toe = -$signed({4'b0000, toe_in_angle});
    end else begin
      s1_toe = $signed({4'b0000, toe_in_angle});
    end
    s1_ang2 = s1_ang + s1_toe;
    s1_abs  = s1_ang2[9] ? 8'(-s1_ang2) : s1_ang2[7:0];
    if (turn_direction_sign == 2'sd0) begin
      s1_negp = 1'b0;
    end else if (turn_direction_sign[1]) begin
      s1_negp = (s1_ang2 > 10'sd0);
    end else begin
      s1_negp = s1_ang2[9];
    end
    s1_sb      = a_sb[ANG_NW];
    s1_sb.flag = a_sb[ANG_NW].side ? s1_negp : !s1_negp;
    s1_sb.zero = (s1_ang2 == 10'sd0);
  end

  logic [7:0]        r_rem [RAD_NW+1];
  logic [RAD_NW-1:0] r_num [RAD_NW+1];
  logic [7:0]        r_den [RAD_NW+1];
  sb_t               r_sb  [RAD_NW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      r_rem[0] <= '0;
      r_num[0] <= RADIUS_SCALE;
      r_den[0] <= s1_abs;
      r_sb[0]  <= s1_sb;
    end
  end

  // Radius divider chain
  for (genvar k = 0; k < RAD_NW; k++) begin : g_rad
    swsd_div_cell #(.NW(RAD_NW), .DW(8)) u_cell (
      .clk(clk), .en(adv),
      .prev_rem(r_rem[k]), .prev_num(r_num[k]), .prev_den(r_den[k]), .prev_sb(r_sb[k]),
      .rem(r_rem[k+1]), .num(r_num[k+1]), .den(r_den[k+1]), .sb(r_sb[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage S2: numerator radius +/- half track
  logic [RAD_NW-1:0]  s2_rad;
  logic signed [12:0] s2_sum;
  logic [11:0]        s2_abs;
  sb_t                s2_sb;

  always_comb begin
    s2_rad = r_num[RAD_NW];
    if (r_sb[RAD_NW].flag) begin
      s2_sum = $signed({2'b00, s2_rad}) + $signed({3'b000, half_track_width});
    end else begin
      s2_sum = $signed({2'b00, s2_rad}) - $signed({3'b000, half_track_width});
    end
    s2_abs     = s2_sum[12] ? 12'(-s2_sum) : s2_sum[11:0];
    s2_sb      = r_sb[RAD_NW];
    s2_sb.flag = s2_sum[12];
  end

  logic [RAD_NW-1:0] b_rem [RAT_NW+1];
  logic [RAT_NW-1:0] b_num [RAT_NW+1];
  logic [RAD_NW-1:0] b_den [RAT_NW+1];
  sb_t               b_sb  [RAT_NW+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      b_rem[0] <= '0;
      b_num[0] <= {s2_abs, 16'h0000};
      b_den[0] <= s2_rad;
      b_sb[0]  <= s2_sb;
    end
  end

  // Ratio divider chain
  for (genvar k = 0; k < RAT_NW; k++) begin : g_rat
    swsd_div_cell #(.NW(RAT_NW), .DW(RAD_NW)) u_cell (
      .clk(clk), .en(adv),
      .prev_rem(b_rem[k]), .prev_num(b_num[k]), .prev_den(b_den[k]), .prev_sb(b_sb[k]),
      .rem(b_rem[k+1]), .num(b_num[k+1]), .den(b_den[k+1]), .sb(b_sb[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage S3: signed Q8.16 ratio, saturated
  logic [RAT_NW-1:0]  s3_qb;
  logic signed [23:0] s3_q;

  always_comb begin
    s3_qb = b_num[RAT_NW];
    if (s3_qb[RAT_NW-1:23] != '0) begin
      s3_q = b_sb[RAT_NW].flag ? 24'sh800000 : 24'sh7FFFFF;
    end else if (b_sb[RAT_NW].flag) begin
      s3_q = -$signed({1'b0, s3_qb[22:0]});
    end else begin
      s3_q = $signed({1'b0, s3_qb[22:0]});
    end
  end

  logic signed [XY_W-1:0] c_x [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] c_y [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  c_z [CORDIC_STEPS+1];
  sb_t                    c_sb [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      c_x[0]  <= XY_W'(65536);
      c_y[0]  <= XY_W'(s3_q);
      c_z[0]  <= '0;
      c_sb[0] <= b_sb[RAT_NW];
    end
  end

  // CORDIC chain
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    swsd_cordic_cell #(.STEP(k)) u_cell (
      .clk(clk), .en(adv),
      .prev_x(c_x[k]), .prev_y(c_y[k]), .prev_z(c_z[k]), .prev_sb(c_sb[k]),
      .x(c_x[k+1]), .y(c_y[k+1]), .z(c_z[k+1]), .sb(c_sb[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage S4: saturate factor, multiply by speed
  logic signed [Z_W-1:0] s4_z;
  logic signed [15:0]    s4_f;
  logic signed [31:0]    s4_prod;
  sb_t                   s4_sb;

  always_comb begin
    s4_z = c_z[CORDIC_STEPS];
    if (s4_z > Z_W'(32767)) begin
      s4_f = 16'sh7FFF;
    end else if (s4_z < -Z_W'(32768)) begin
      s4_f = 16'sh8000;
    end else begin
      s4_f = s4_z[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_prod <= s4_f * c_sb[CORDIC_STEPS].speed;
      s4_sb   <= c_sb[CORDIC_STEPS];
    end
  end

  // --------------------------------------------------------------------------
  // Stage S5: divide by 2^14 toward zero, saturate to 17 bits
  logic signed [31:0] s5_bias;
  logic signed [31:0] s5_sh;
  logic signed [16:0] s5_res;
  logic signed [16:0] s5_out;

  always_comb begin
    s5_bias = s4_prod + (s4_prod[31] ? 32'sd16383 : 32'sd0);
    s5_sh   = s5_bias >>> 14;
    if (s5_sh > 32'sd65535) begin
      s5_res = 17'sh0FFFF;
    end else if (s5_sh < -32'sd65536) begin
      s5_res = 17'sh10000;
    end else begin
      s5_res = s5_sh[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_out <= s4_sb.zero ? 17'(s4_sb.speed) : s5_res;
    end
  end

  // --------------------------------------------------------------------------
  // Output buffer: head register plus one skid entry
  logic signed [16:0] out_data;
  logic signed [16:0] skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= s5_out;
      end else begin
        out_data  <= s5_out;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_data <= s5_out;
      end else begin
        out_data  <= s5_out;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.wheel_speed = out_data;

endmodule

@@ src/swsd_checker.sv @@
// ----------------------------------------------------------------------------
// swsd_checker
// Port-level checks for the steering wheel speed differential.
// ----------------------------------------------------------------------------
module swsd_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [16:0] wheel_speed
);

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // an empty or draining output never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!result_valid || result_ready) |-> item_ready)
    else $error("input stalled with room at the output");

  // a pending result stays until taken
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid)
    else $error("result dropped before taken");

  // a stalled result keeps its value
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> $stable(wheel_speed))
    else $error("result changed while stalled");

endmodule

bind steering_wheel_speed_differential_top swsd_port_checks u_swsd_port_checks (
  .clk(clk),
  .rst(rst),
  .item_ready(item.ready),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .wheel_speed(result.wheel_speed)
);
